[design/cspmv_pkg.sv]
// Shared types and constants for the CSR sparse matrix-vector dot block.
// No dependencies.
package cspmv_pkg;

    localparam int VECTOR_LENGTH_DEF = 256;
    localparam int ROW_COUNT_DEF     = 256;

    localparam int VALUE_W = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;

    // result queue depth: the two pipeline stages plus the entry draining at m_,
    // plus one so s_ready stays high at full rate
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_NONZERO = 2'd1;
    localparam logic [1:0] CMD_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [7:0]                column;
        logic signed [VALUE_W-1:0] value;
        logic                      row_last;
    } in_t;

    typedef struct packed {
        logic [7:0]              row_index;
        logic signed [ACC_W-1:0] dot_product;
    } out_t;

endpackage

[design/cspmv_out_queue.sv]
// Small result queue that decouples the accumulate stage from the output port.
// Depends on cspmv_pkg.
module cspmv_out_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  cspmv_pkg::out_t                     push_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output cspmv_pkg::out_t                     m_payload,
    output logic [cspmv_pkg::QUEUE_CW-1:0]      count
);

    cspmv_pkg::out_t entry_reg [cspmv_pkg::QUEUE_DEPTH];

    logic [cspmv_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cspmv_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cspmv_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic                           pop;

    assign m_valid   = (count_reg != '0);
    assign m_payload = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/csr_sparse_matrix_vector_dot.sv]
// Top level: CSR sparse matrix times dense vector, fixed-point, streamed by rows.
// Depends on cspmv_pkg and cspmv_out_queue.
//
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   cspmv_pkg::in_t  (cmd, column, value, row_last)
//  m_        out  m_valid / m_ready   cspmv_pkg::out_t (row_index, dot_product)
//
// One transfer per cycle on s_ when the result side keeps up; an input transfer
// becomes its result at m_ through the store read, the multiply and the
// accumulate, then the result queue.
// s_ready drops while the 4-entry result queue plus the two pipeline stages
// hold 4 items, so a stalled m_ side stops input within that many transfers.
// Reset (aresetn low, synchronous) clears accumulator, row counter, pipeline
// valids and the queue; the vector store holds garbage until loaded.
// Loads write the store at transfer time, so a nonzero right behind a load
// at the same column already reads the new element.
module csr_sparse_matrix_vector_dot #(
    parameter int VECTOR_LENGTH = cspmv_pkg::VECTOR_LENGTH_DEF,
    parameter int ROW_COUNT     = cspmv_pkg::ROW_COUNT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cspmv_pkg::in_t  s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output cspmv_pkg::out_t m_payload
);

    localparam int AddrW = $clog2(VECTOR_LENGTH);
    localparam int RowW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int OccW  = cspmv_pkg::QUEUE_CW + 1;
    localparam int SumW  = cspmv_pkg::ACC_W + 1;

    // dense vector store, one write and one registered read per cycle
    logic signed [cspmv_pkg::VALUE_W-1:0] vec_mem [VECTOR_LENGTH];

    logic             in_fire;
    logic [AddrW-1:0] in_addr;
    logic             in_range;

    // stage 1: store read data lands here
    logic                                 s1_valid_reg;
    logic [1:0]                           s1_cmd_reg;
    logic signed [cspmv_pkg::VALUE_W-1:0] s1_value_reg;
    logic                                 s1_last_reg;
    logic                                 s1_in_range_reg;
    logic signed [cspmv_pkg::VALUE_W-1:0] s1_rd_data_reg;
    logic signed [cspmv_pkg::VALUE_W-1:0] s1_elem;
    logic signed [cspmv_pkg::PROD_W-1:0]  s1_product;

    // stage 2: product registered, accumulate and emit
    logic                                s2_valid_reg;
    logic [1:0]                          s2_cmd_reg;
    logic                                s2_last_reg;
    logic signed [cspmv_pkg::PROD_W-1:0] s2_prod_reg;

    logic signed [cspmv_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [RowW-1:0]                    row_reg, row_next, row_adv;
    logic signed [SumW-1:0]             sum_wide;
    logic signed [cspmv_pkg::ACC_W-1:0] sum_sat;

    logic                          push;
    cspmv_pkg::out_t               push_data;
    logic [cspmv_pkg::QUEUE_CW-1:0] q_count;
    logic [OccW-1:0]               occupancy;

    // ---------------- input side and store access ----------------
    assign occupancy = OccW'(q_count) + OccW'(s1_valid_reg) + OccW'(s2_valid_reg);
    assign s_ready   = (occupancy < OccW'(cspmv_pkg::QUEUE_DEPTH));
    assign in_fire   = s_valid && s_ready;
    assign in_addr   = AddrW'(s_payload.column);
    assign in_range  = (32'(s_payload.column) < 32'(VECTOR_LENGTH));

    always_ff @(posedge aclk) begin
        if (in_fire && (s_payload.cmd == cspmv_pkg::CMD_LOAD) && in_range) begin
            vec_mem[in_addr] <= s_payload.value;
        end
        s1_rd_data_reg <= vec_mem[in_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_cmd_reg      <= s_payload.cmd;
            s1_value_reg    <= s_payload.value;
            s1_last_reg     <= s_payload.row_last;
            s1_in_range_reg <= in_range;
        end
    end

    // ---------------- stage 1: multiply ----------------
    // column past the vector end multiplies by zero
    assign s1_elem    = s1_in_range_reg ? s1_rd_data_reg : '0;
    assign s1_product = s1_value_reg * s1_elem;

    always_ff @(posedge aclk) begin
        s2_cmd_reg  <= s1_cmd_reg;
        s2_last_reg <= s1_last_reg;
        s2_prod_reg <= s1_product;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- stage 2: saturating accumulate ----------------
    assign sum_wide = SumW'(acc_reg) + SumW'(s2_prod_reg);

    always_comb begin
        if (sum_wide[SumW-1] != sum_wide[SumW-2]) begin
            sum_sat = sum_wide[SumW-1] ? {1'b1, {(cspmv_pkg::ACC_W-1){1'b0}}}
                                       : {1'b0, {(cspmv_pkg::ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[cspmv_pkg::ACC_W-1:0];
        end
    end

    // row counter wraps after the last row
    assign row_adv = (row_reg == RowW'(ROW_COUNT - 1)) ? '0 : row_reg + 1'b1;

    always_comb begin
        acc_next               = acc_reg;
        row_next               = row_reg;
        push                   = 1'b0;
        push_data.row_index    = 8'(row_reg);
        push_data.dot_product  = '0;
        if (s2_valid_reg) begin
            case (s2_cmd_reg)
                cspmv_pkg::CMD_LOAD: begin
                    row_next = '0;
                end
                cspmv_pkg::CMD_NONZERO: begin
                    if (s2_last_reg) begin
                        push                  = 1'b1;
                        push_data.dot_product = sum_sat;
                        acc_next              = '0;
                        row_next              = row_adv;
                    end else begin
                        acc_next = sum_sat;
                    end
                end
                cspmv_pkg::CMD_EMPTY: begin
                    push     = 1'b1;
                    acc_next = '0;
                    row_next = row_adv;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            row_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            row_reg <= row_next;
        end
    end

    // ---------------- result queue ----------------
    cspmv_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload),
        .count     (q_count)
    );

    // ---------------- assertions ----------------
    a_no_overcommit: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= OccW'(cspmv_pkg::QUEUE_DEPTH))
        else $error("queue and pipeline hold more items than the queue can take");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count < cspmv_pkg::QUEUE_CW'(cspmv_pkg::QUEUE_DEPTH))
                 || (m_valid && m_ready))
        else $error("result pushed into a full queue");

    a_acc_clear_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (acc_reg == '0))
        else $error("accumulator not cleared after a row result");

    a_load_restarts_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && (s2_cmd_reg == cspmv_pkg::CMD_LOAD)) |=> (row_reg == '0))
        else $error("row counter not restarted by a load");

endmodule
